>>> rtl/core/bicn_pkg.sv
// package with sizes and action codes for the inequality classify and normalize block
`timescale 1ns / 1ps
`default_nettype none

package bicn_pkg;

    localparam int MAX_DIMS = 8;
    localparam int TERM_W   = 16;
    localparam int SLOTS    = MAX_DIMS + 1;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int DIMS_W   = 4;
    localparam int SUM_W    = TERM_W + $clog2(SLOTS) + 1;
    localparam int CNT_W    = $clog2(TERM_W);

    localparam int IN_W   = 32;
    localparam int USER_W = 2;
    localparam int OUT_W  = 40;

    typedef enum logic [1:0] {
        ACT_WRITE     = 2'd0,
        ACT_READ      = 2'd1,
        ACT_NORMALIZE = 2'd2,
        ACT_CLASSIFY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CLS_INSIDE  = 2'd0,
        CLS_ON      = 2'd1,
        CLS_OUTSIDE = 2'd2
    } point_class_t;

    typedef logic signed [TERM_W-1:0] term_t;

endpackage

`default_nettype wire

>>> rtl/core/bit_inequality_classify_normalize_top.sv
// linear inequality store with point classify and gcd normalize on one shared divider
//
// input stream s_*: s_tuser carries the action (write, read, normalize, classify),
// s_tdata the slot index, the coefficient value and the point bit-vector.
// output stream m_*: one result transaction per input transaction, in order.
// cfg_wr_en / cfg_wr_data set dims_in_use (clamped to 1..MAX_DIMS); the user must write
// them only while idle, the block does not enforce this. one transaction is worked on at
// a time; s_tready is low while busy and while a result still waits in the output register,
// and rises the cycle after the result transaction is taken.
// write and read: the result is valid in the cycle after acceptance.
// classify: one adder step per coefficient.
// normalize: per term a fetch step, then one pass of the shared restoring divider for
// each remainder step of the euclid loop, then a divide-back pass over every term
// when the gcd exceeds one, or none when the gcd is one.
// a stall on m_tready holds the result and blocks new input.
// reset (aresetn low, synchronous) clears all coefficients, sets dims_in_use to
// MAX_DIMS and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module bit_inequality_classify_normalize_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bicn_pkg::DIMS_W-1:0] cfg_wr_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // term_index[3:0], term_value[19:4], point[27:20], zero pad
    input  wire logic [bicn_pkg::IN_W-1:0]   s_tdata,
    // action[1:0]
    input  wire logic [bicn_pkg::USER_W-1:0] s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // point_class[1:0], divisor[17:2], read_value[33:18], zero_vector[34], zero pad
    output logic [bicn_pkg::OUT_W-1:0]       m_tdata
);

    import bicn_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLS_RUN,
        ST_GCD_FETCH,
        ST_GCD_DIV,
        ST_NORM_FETCH,
        ST_NORM_DIV
    } state_t;

    state_t               state_reg;
    term_t                store_reg [SLOTS];
    logic [DIMS_W-1:0]    dims_reg;
    logic [IDX_W-1:0]     j_reg;
    logic [7:0]           point_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [TERM_W-1:0]    g_reg;
    logic                 neg_reg;
    logic [TERM_W-1:0]    div_acc_reg;
    logic [TERM_W-1:0]    div_q_reg;
    logic [TERM_W-1:0]    div_d_reg;
    logic [CNT_W-1:0]     div_cnt_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_cls_reg;
    logic [15:0]          out_div_reg;
    logic [15:0]          out_rd_reg;
    logic                 out_zv_reg;

    action_t              in_action;
    logic [3:0]           in_index;
    logic signed [15:0]   in_value;
    logic [7:0]           in_point;
    logic                 in_accept;
    logic                 idx_ok;
    logic [IDX_W-1:0]     rd_addr;
    term_t                rd_term;
    logic [TERM_W-1:0]    rd_mag;
    logic                 j_last;
    logic                 div_last;
    logic [TERM_W:0]      div_sh;
    logic [TERM_W:0]      div_trial;
    logic                 div_ge;
    logic [TERM_W-1:0]    div_acc_next;
    logic [TERM_W-1:0]    div_q_next;
    logic [DIMS_W-1:0]    cfg_dims;
    logic                 pt_bit;

    assign in_action = action_t'(s_tuser[1:0]);
    assign in_index  = s_tdata[3:0];
    assign in_value  = s_tdata[19:4];
    assign in_point  = s_tdata[27:20];

    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign idx_ok    = (32'(in_index) <= MAX_DIMS);

    // single read port into the coefficient registers
    always_comb begin
        if (state_reg == ST_IDLE) begin
            if (in_action == ACT_CLASSIFY) begin
                rd_addr = IDX_W'(dims_reg);
            end else if (idx_ok) begin
                rd_addr = IDX_W'(in_index);
            end else begin
                rd_addr = '0;
            end
        end else begin
            rd_addr = j_reg;
        end
    end

    assign rd_term = store_reg[rd_addr];
    assign rd_mag  = rd_term[TERM_W-1] ? (~rd_term + TERM_W'(1)) : rd_term;
    assign j_last  = (j_reg == IDX_W'(dims_reg));
    assign pt_bit  = (32'(j_reg) < 8) ? point_reg[j_reg[2:0]] : 1'b0;

    // restoring divider step
    assign div_sh       = {div_acc_reg, div_q_reg[TERM_W-1]};
    assign div_trial    = div_sh - {1'b0, div_d_reg};
    assign div_ge       = !div_trial[TERM_W];
    assign div_acc_next = div_ge ? div_trial[TERM_W-1:0] : div_sh[TERM_W-1:0];
    assign div_q_next   = {div_q_reg[TERM_W-2:0], div_ge};
    assign div_last     = (div_cnt_reg == CNT_W'(TERM_W - 1));

    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_dims = DIMS_W'(1);
        end else if (32'(cfg_wr_data) > MAX_DIMS) begin
            cfg_dims = DIMS_W'(MAX_DIMS);
        end else begin
            cfg_dims = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dims_reg      <= DIMS_W'(MAX_DIMS);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                dims_reg <= cfg_dims;
            end
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        out_cls_reg <= '0;
                        out_div_reg <= '0;
                        out_rd_reg  <= (in_action == ACT_READ && idx_ok) ? 16'(rd_term) : '0;
                        out_zv_reg  <= 1'b0;
                        j_reg       <= '0;
                        g_reg       <= '0;
                        point_reg   <= in_point;
                        unique case (in_action)
                            ACT_WRITE: begin
                                if (idx_ok) begin
                                    store_reg[IDX_W'(in_index)] <= TERM_W'(in_value);
                                end
                                out_valid_reg <= 1'b1;
                            end
                            ACT_READ: begin
                                out_valid_reg <= 1'b1;
                            end
                            ACT_NORMALIZE: begin
                                state_reg <= ST_GCD_FETCH;
                            end
                            default: begin
                                sum_reg   <= -SUM_W'(rd_term);
                                state_reg <= ST_CLS_RUN;
                            end
                        endcase
                    end
                end
                ST_CLS_RUN: begin
                    if (j_last) begin
                        if (sum_reg > 0) begin
                            out_cls_reg <= CLS_INSIDE;
                        end else if (sum_reg == 0) begin
                            out_cls_reg <= CLS_ON;
                        end else begin
                            out_cls_reg <= CLS_OUTSIDE;
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end else begin
                        if (pt_bit) begin
                            sum_reg <= sum_reg + SUM_W'(rd_term);
                        end
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                ST_GCD_FETCH: begin
                    if (rd_mag != '0 && g_reg != '0) begin
                        div_q_reg   <= g_reg;
                        div_d_reg   <= rd_mag;
                        div_acc_reg <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_GCD_DIV;
                    end else if (j_last) begin
                        if (g_reg == '0 && rd_mag == '0) begin
                            out_zv_reg    <= 1'b1;
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end else begin
                            if (g_reg == '0) begin
                                g_reg <= rd_mag;
                            end
                            j_reg     <= '0;
                            state_reg <= ST_NORM_FETCH;
                        end
                    end else begin
                        if (g_reg == '0) begin
                            g_reg <= rd_mag;
                        end
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                ST_GCD_DIV: begin
                    if (div_last) begin
                        div_cnt_reg <= '0;
                        div_acc_reg <= '0;
                        if (div_acc_next == '0) begin
                            g_reg <= div_d_reg;
                            if (j_last) begin
                                j_reg     <= '0;
                                state_reg <= ST_NORM_FETCH;
                            end else begin
                                j_reg     <= j_reg + IDX_W'(1);
                                state_reg <= ST_GCD_FETCH;
                            end
                        end else begin
                            div_q_reg <= div_d_reg;
                            div_d_reg <= div_acc_next;
                        end
                    end else begin
                        div_acc_reg <= div_acc_next;
                        div_q_reg   <= div_q_next;
                        div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                    end
                end
                ST_NORM_FETCH: begin
                    if (g_reg == TERM_W'(1)) begin
                        out_div_reg   <= 16'(g_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end else begin
                        div_q_reg   <= rd_mag;
                        div_d_reg   <= g_reg;
                        div_acc_reg <= '0;
                        div_cnt_reg <= '0;
                        neg_reg     <= rd_term[TERM_W-1];
                        state_reg   <= ST_NORM_DIV;
                    end
                end
                ST_NORM_DIV: begin
                    if (div_last) begin
                        store_reg[j_reg] <= neg_reg ? (~div_q_next + TERM_W'(1)) : div_q_next;
                        if (j_last) begin
                            out_div_reg   <= 16'(g_reg);
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end else begin
                            j_reg     <= j_reg + IDX_W'(1);
                            state_reg <= ST_NORM_FETCH;
                        end
                    end else begin
                        div_acc_reg <= div_acc_next;
                        div_q_reg   <= div_q_next;
                        div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_zv_reg, out_rd_reg, out_div_reg, out_cls_reg};

endmodule

`default_nettype wire
